@@ rtl/prpd_pkg.sv @@
// ----------------------------------------------------------------------------
// prpd_pkg
// Shared constants, types and register codes of the pulse-rate peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package prpd_pkg;

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int BPM_W    = 16;
   localparam int CNT_W    = 16;
   localparam int NUM_W    = 16;
   localparam int HOLD_W   = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // Moving-average filter
   localparam int FILTER_TAPS = 10;
   localparam int PTR_W   = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
   localparam int SUM_W   = $clog2(FILTER_TAPS * ((1 << SAMPLE_W) - 1) + 1);
   localparam int TAP_LOG = $clog2(FILTER_TAPS);
   // sum / FILTER_TAPS as sum * RECIP >> SHIFT, exact over the whole sum range
   localparam int SHIFT   = SUM_W + TAP_LOG;
   localparam int RECIP   = ((1 << SHIFT) + FILTER_TAPS - 1) / FILTER_TAPS;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;

   // Divider
   localparam int STEP_W = $clog2(BPM_W);

   // Result queue between front and back (depth a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   // Register codes
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_NUMERATOR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_COUNT     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_LEVEL = CSR_IDX_W'(2);

   // Register reset values
   localparam logic [NUM_W-1:0]    RATE_NUMERATOR_RST = NUM_W'(12000);
   localparam logic [HOLD_W-1:0]   HOLD_COUNT_RST     = HOLD_W'(40);
   localparam logic [SAMPLE_W-1:0] BASELINE_LEVEL_RST = SAMPLE_W'(2048);

   typedef struct packed {
      logic [NUM_W-1:0]    rate_numerator;
      logic [HOLD_W-1:0]   hold_count;
      logic [SAMPLE_W-1:0] baseline_level;
   } cfg_type;

   // One division job: numerator / peak position
   typedef struct packed {
      logic [NUM_W-1:0] numerator;
      logic [CNT_W-1:0] position;
   } job_type;

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_AVG    = 3'b010,
      F_DECIDE = 3'b100
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_OUT  = 3'b100
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/prpd_channels.sv @@
// ----------------------------------------------------------------------------
// prpd channels
// Valid/ready channel interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface prpd_req_if;
   logic                           valid;
   logic                           ready;
   logic [prpd_pkg::SAMPLE_W-1:0]  sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface prpd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [prpd_pkg::BPM_W-1:0]     beats_per_minute;
   modport source (output valid, output beats_per_minute, input ready);
   modport sink   (input valid, input beats_per_minute, output ready);
endinterface

interface prpd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [prpd_pkg::CSR_IDX_W-1:0]   index;
   logic [prpd_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pulse_rate_peak_detector.sv @@
// ----------------------------------------------------------------------------
// pulse_rate_peak_detector
// Moving-average pulse sensor peak detector giving beats per minute.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries one 12-bit sensor sample per transfer. The front end
//    takes a sample in F_IDLE, averages it in F_AVG and updates the peak
//    tracker in F_DECIDE; it takes no new sample until it is back in
//    F_IDLE, nor while the job queue is full.
//  - rsp_bus carries beats_per_minute, one transfer per confirmed peak.
//    The result leaves the output register after the sample that
//    confirmed it has passed F_AVG, F_DECIDE, the queue and the 16-step
//    restoring divider, which takes no new job until its result is taken.
//  - csr_bus writes rate_numerator (0), hold_count (1), baseline_level (2);
//    other indexes are ignored. It is always ready; write only when idle.
//  - Reset (synchronous) clears the filter ring, counters and peak state
//    and restores register defaults 12000, 40 and 2048.
//  - A stalled rsp_bus holds its result; a two-job queue absorbs further
//    confirmed peaks, and once it is full req_bus.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_rate_peak_detector (
   input  logic       clock,
   input  logic       reset,
   prpd_req_if.sink   req_bus,
   prpd_rsp_if.source rsp_bus,
   prpd_csr_if.sink   csr_bus
);
   import prpd_pkg::*;

   // configuration registers
   cfg_type  cfg_ff;

   // front to queue
   logic     q_push;
   job_type  q_push_job;
   logic     q_full;

   // queue to back
   logic     q_valid;
   job_type  q_pop_job;
   logic     q_pop;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_numerator <= RATE_NUMERATOR_RST;
         cfg_ff.hold_count     <= HOLD_COUNT_RST;
         cfg_ff.baseline_level <= BASELINE_LEVEL_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_RATE_NUMERATOR: cfg_ff.rate_numerator <= NUM_W'(csr_bus.data);
            CSR_HOLD_COUNT:     cfg_ff.hold_count     <= HOLD_W'(csr_bus.data);
            CSR_BASELINE_LEVEL: cfg_ff.baseline_level <= csr_bus.data[SAMPLE_W-1:0];
            default: ; // unknown index: write dropped
         endcase
      end
   end

   // filter, counter and peak tracking
   prpd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_bus),
      .q_push (q_push),
      .q_job  (q_push_job),
      .q_full (q_full)
   );

   // short job queue so the tracker keeps running while a result stalls
   prpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_job   (q_pop_job),
      .pop       (q_pop)
   );

   // rate division and output register
   prpd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (q_pop_job),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule

`default_nettype wire

@@ rtl/prpd_front.sv @@
// ----------------------------------------------------------------------------
// prpd_front
// Sample filter and peak tracker; issues a division job per confirmed peak.
// ----------------------------------------------------------------------------
`default_nettype none

module prpd_front (
   input  logic              clock,
   input  logic              reset,
   input  prpd_pkg::cfg_type cfg,
   prpd_req_if.sink          req,
   output logic              q_push,
   output prpd_pkg::job_type q_job,
   input  logic              q_full
);
   import prpd_pkg::*;

   front_state_type      state_ff, state_in;
   logic [SAMPLE_W-1:0]  ring_ff [FILTER_TAPS];
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [SAMPLE_W-1:0]  avg_ff, avg_in;
   logic [CNT_W-1:0]     counter_ff, counter_in;
   logic [SAMPLE_W-1:0]  peak_ff, peak_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [HOLD_W-1:0]    below_ff, below_in;
   logic                 confirmed_ff, confirmed_in;

   logic                 accept;
   logic [PROD_W-1:0]    product;
   logic [CNT_W-1:0]     cnt_inc;
   logic [HOLD_W-1:0]    below_inc;

   assign req.ready = (state_ff == F_IDLE) && !q_full;
   assign accept    = req.valid && req.ready;
   assign product   = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign cnt_inc   = counter_ff + CNT_W'(1);
   assign below_inc = (below_ff == '1) ? below_ff : below_ff + HOLD_W'(1);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      counter_in   = counter_ff;
      peak_in      = peak_ff;
      pos_in       = pos_ff;
      below_in     = below_ff;
      confirmed_in = confirmed_ff;
      q_push       = 1'b0;
      q_job        = '{numerator: cfg.rate_numerator, position: pos_ff};
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               // running sum: drop the oldest entry, add the new one
               sum_in = sum_ff - SUM_W'(ring_ff[ptr_ff]) + SUM_W'(req.sample);
               ptr_in = (ptr_ff == PTR_W'(FILTER_TAPS - 1)) ? '0 : ptr_ff + PTR_W'(1);
               state_in = F_AVG;
            end
         end
         F_AVG: begin
            avg_in   = product[SHIFT +: SAMPLE_W];
            state_in = F_DECIDE;
         end
         F_DECIDE: begin
            counter_in = cnt_inc;
            if (avg_ff > peak_ff) begin
               peak_in      = avg_ff;
               pos_in       = cnt_inc;
               confirmed_in = 1'b0;
               below_in     = '0;
            end else if (avg_ff < cfg.baseline_level) begin
               below_in = below_inc;
               if (!confirmed_ff && (below_inc >= cfg.hold_count)) begin
                  q_push       = 1'b1;
                  counter_in   = cnt_inc - pos_ff;
                  peak_in      = cfg.baseline_level;
                  confirmed_in = 1'b1;
                  below_in     = '0;
               end
            end
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         counter_ff   <= '0;
         peak_ff      <= '0;
         pos_ff       <= '0;
         below_ff     <= '0;
         confirmed_ff <= 1'b0;
         for (int i = 0; i < FILTER_TAPS; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         counter_ff   <= counter_in;
         peak_ff      <= peak_in;
         pos_ff       <= pos_in;
         below_ff     <= below_in;
         confirmed_ff <= confirmed_in;
         if (accept) begin
            ring_ff[ptr_ff] <= req.sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (state_ff == F_DECIDE) && !q_full)
      else $error("job pushed outside decide step or into a full queue");

   a_accept_to_avg: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == F_AVG))
      else $error("accepted sample not followed by averaging step");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(FILTER_TAPS - 1))
      else $error("ring pointer out of range");

endmodule

`default_nettype wire

@@ rtl/prpd_queue.sv @@
// ----------------------------------------------------------------------------
// prpd_queue
// Two-entry job queue decoupling the peak tracker from the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module prpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  prpd_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   output prpd_pkg::job_type pop_job,
   input  logic              pop
);
   import prpd_pkg::*;

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, rd_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ rtl/prpd_back.sv @@
// ----------------------------------------------------------------------------
// prpd_back
// Bit-serial restoring divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  prpd_pkg::job_type q_job,
   output logic              q_pop,
   prpd_rsp_if.source        rsp
);
   import prpd_pkg::*;

   back_state_type      state_ff, state_in;
   logic [BPM_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    div_ff, div_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [CNT_W:0]      rem_sh;
   logic [CNT_W+1:0]    diff;

   // zero divisor never goes negative, so the quotient comes out all ones
   assign rem_sh = {rem_ff, quo_ff[BPM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, div_ff};

   assign rsp.valid            = (state_ff == B_OUT);
   assign rsp.beats_per_minute = quo_ff;

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               quo_in   = BPM_W'(q_job.numerator);
               rem_in   = '0;
               div_in   = q_job.position;
               step_in  = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            quo_in  = {quo_ff[BPM_W-2:0], ~diff[CNT_W+1]};
            rem_in  = diff[CNT_W+1] ? rem_sh[CNT_W-1:0] : diff[CNT_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(BPM_W - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (rsp.ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == B_IDLE) && q_valid)
      else $error("job taken while divider busy");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) && (step_ff == STEP_W'(BPM_W - 1)) |=> rsp.valid)
      else $error("division finished without presenting result");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) && (div_ff != '0) |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

endmodule

`default_nettype wire
